// ===== design/mctd_pkg.sv =====
// ----------------------------------------------------------------------------
// mctd_pkg
// Types and constants for the multi-channel timestamp switch debouncer.
// ----------------------------------------------------------------------------
package mctd_pkg;

    localparam int DEF_CHANNELS = 32;
    localparam int CHANNEL_W    = 5;
    localparam int TIME_W       = 32;
    localparam int SETTLE_W     = 8;

    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic                 raw_level;
        logic [TIME_W-1:0]    now_ms;
        logic [SETTLE_W-1:0]  settle_ms;
    } in_item_t;

    typedef struct packed {
        logic stable_pressed;
        logic changed;
    } out_item_t;

    // Per-channel entry held in the state memory.
    typedef struct packed {
        logic              stable;
        logic              bouncing;
        logic [TIME_W-1:0] start;
    } entry_t;

endpackage

// ===== design/multi_channel_timestamp_debouncer_core.sv =====
// ----------------------------------------------------------------------------
// multi_channel_timestamp_debouncer_core
// Per-channel switch debouncer, channel state held in one synchronous memory.
// ----------------------------------------------------------------------------
// Path: memory read into stage 1, then update and output register.
// Throughput: one item per cycle unless out_ready stalls the output; set by
// the single read-modify-write of the channel entry, with the last write
// forwarded to a back-to-back access.
// Reset: per-entry valid flops clear at once, so every channel reads as
// released and not bouncing; no clearing pass.
// ----------------------------------------------------------------------------
module multi_channel_timestamp_debouncer_core #(
    parameter int CHANNELS = mctd_pkg::DEF_CHANNELS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mctd_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output mctd_pkg::out_item_t out_item
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // state memory and per-entry valid bits
    mctd_pkg::entry_t  mem [CHANNELS];
    logic [CHANNELS-1:0] ent_valid_reg;

    // stage 1: item waiting on its memory read
    logic               s1_valid_reg;
    mctd_pkg::in_item_t s1_item_reg;
    logic               s1_in_range_reg;
    mctd_pkg::entry_t   rd_data_reg;
    logic               rd_valid_reg;

    // last write, for forwarding
    logic               fwd_valid_reg;
    logic [IDX_W-1:0]   fwd_addr_reg;
    mctd_pkg::entry_t   fwd_data_reg;

    // output register
    logic                out_valid_reg;
    mctd_pkg::out_item_t out_item_reg;

    logic               out_load;
    logic               s1_adv;
    logic               accept;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   s1_addr;
    logic               in_range;
    mctd_pkg::entry_t   cur;
    mctd_pkg::entry_t   upd;
    logic               pressed_now;
    logic               chg;
    logic [mctd_pkg::TIME_W-1:0] elapsed;
    logic               do_write;

    assign out_load = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_load;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    assign rd_addr  = IDX_W'(in_item.channel);
    assign s1_addr  = IDX_W'(s1_item_reg.channel);
    assign in_range = 32'(in_item.channel) < 32'(CHANNELS);

    // entry as seen by the stage-1 item
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr))
        begin
            cur = fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            cur = rd_data_reg;
        end
        else
        begin
            cur = '0;
        end
    end

    assign pressed_now = ~s1_item_reg.raw_level;
    assign elapsed     = s1_item_reg.now_ms - cur.start;

    always_comb
    begin
        upd = cur;
        chg = 1'b0;
        if (pressed_now == cur.stable)
        begin
            upd.bouncing = 1'b0;
            upd.start    = '0;
        end
        else if (!cur.bouncing)
        begin
            upd.bouncing = 1'b1;
            upd.start    = s1_item_reg.now_ms;
        end
        else if (elapsed >= mctd_pkg::TIME_W'(s1_item_reg.settle_ms))
        begin
            upd.stable   = pressed_now;
            upd.bouncing = 1'b0;
            upd.start    = '0;
            chg          = 1'b1;
        end
    end

    assign do_write = s1_adv && s1_in_range_reg;

    // memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[s1_addr] <= upd;
        end
        if (accept)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_write)
            begin
                ent_valid_reg[s1_addr] <= 1'b1;
                fwd_valid_reg          <= 1'b1;
            end
            if (accept)
            begin
                // out-of-range items never use the read value
                rd_valid_reg <= in_range ? ent_valid_reg[rd_addr] : 1'b0;
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg     <= in_item;
            s1_in_range_reg <= in_range;
        end
        if (do_write)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= upd;
        end
        if (s1_adv)
        begin
            if (s1_in_range_reg)
            begin
                out_item_reg.stable_pressed <= upd.stable;
                out_item_reg.changed        <= chg;
            end
            else
            begin
                out_item_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
